@@ rtl/drpi_pkg.sv @@
// Shared types and constants for the dumped packet reinjector.
// No dependencies; used by drpi_outq, drpi_ctrl and the top level.
package drpi_pkg;

  // Request codes
  localparam logic [1:0] REQ_DUMP = 2'd0;
  localparam logic [1:0] REQ_TICK = 2'd1;
  localparam logic [1:0] REQ_TXRDY = 2'd2;

  // Header field positions
  localparam int unsigned TYPE_LSB = 22;
  localparam int unsigned ROUTE_LSB = 24;
  localparam int unsigned CONTROL_LSB = 16;
  localparam int unsigned PLD_BIT = 17;
  localparam int unsigned PLD_IN_CTRL = PLD_BIT - CONTROL_LSB;
  localparam logic [1:0] TYPE_MCAST = 2'b00;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        router_blocked;
    logic [31:0] header;
    logic [31:0] key;
    logic [31:0] payload;
  } req_t;

  typedef struct packed {
    logic        send;
    logic [7:0]  send_control;
    logic [2:0]  send_route;
    logic [7:0]  send_source;
    logic        send_has_payload;
    logic [31:0] send_payload;
    logic [31:0] send_key;
    logic        dropped;
    logic        bouncing;
  } rsp_t;

  // One queued packet: only the header bits that are re-sent are kept
  typedef struct packed {
    logic [7:0]  control;
    logic [2:0]  route;
    logic [31:0] key;
    logic [31:0] payload;
  } entry_t;

endpackage

@@ rtl/drpi_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module drpi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/drpi_outq.sv @@
// Two-entry response queue between the controller and the response port.
// Depends on drpi_pkg.
module drpi_outq (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  drpi_pkg::rsp_t  push_data,
  output logic            full,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output drpi_pkg::rsp_t  rsp
);

  drpi_pkg::rsp_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = rsp_valid && !rsp_stall;
  assign rsp_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign rsp       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/drpi_ctrl.sv @@
// Queue controller: head/tail pointers, bounce flag, source id and the
// request sequencer that drives the packet store. Depends on drpi_pkg.
module drpi_ctrl #(
  parameter int QUEUE_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [7:0]                     cfg_wr_data,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  drpi_pkg::req_t                 req,
  input  logic                           q_full,
  output logic                           res_push,
  output drpi_pkg::rsp_t                 res,
  output logic                           busy,
  output logic                           mem_wr_en,
  output logic [$clog2(QUEUE_DEPTH)-1:0] mem_wr_addr,
  output drpi_pkg::entry_t               mem_wr_data,
  output logic                           mem_rd_en,
  output logic [$clog2(QUEUE_DEPTH)-1:0] mem_rd_addr,
  input  drpi_pkg::entry_t               mem_rd_data
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam logic [PtrW-1:0] LastSlot = PtrW'(QUEUE_DEPTH - 1);

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  state_t          state;
  state_t          state_next;
  logic [PtrW-1:0] head;
  logic [PtrW-1:0] head_next;
  logic [PtrW-1:0] tail;
  logic [PtrW-1:0] tail_next;
  logic            bounce;
  logic            bounce_next;
  logic [7:0]      source_id;

  logic            accept;
  logic            empty;
  logic [PtrW-1:0] head_inc;
  logic [PtrW-1:0] tail_inc;
  logic            has_pld;

  assign busy      = (state != ST_IDLE);
  assign req_stall = busy || q_full;
  assign accept    = req_valid && !req_stall;
  assign empty     = (head == tail);
  assign head_inc  = (head == LastSlot) ? '0 : head + 1'b1;
  assign tail_inc  = (tail == LastSlot) ? '0 : tail + 1'b1;
  assign has_pld   = mem_rd_data.control[drpi_pkg::PLD_IN_CTRL];

  assign mem_wr_addr = tail;
  assign mem_rd_addr = head;
  assign mem_wr_data = '{
    control: req.header[drpi_pkg::CONTROL_LSB +: 8],
    route:   req.header[drpi_pkg::ROUTE_LSB +: 3],
    key:     req.key,
    payload: req.payload
  };

  always_comb begin
    state_next  = state;
    head_next   = head;
    tail_next   = tail;
    bounce_next = bounce;
    mem_wr_en   = 1'b0;
    mem_rd_en   = 1'b0;
    res_push    = 1'b0;
    res         = '0;

    if (state == ST_READ) begin
      // popped entry is back from the store
      res_push             = 1'b1;
      res.send             = 1'b1;
      res.send_control     = mem_rd_data.control;
      res.send_route       = mem_rd_data.route;
      res.send_source      = source_id;
      res.send_has_payload = has_pld;
      res.send_payload     = has_pld ? mem_rd_data.payload : '0;
      res.send_key         = mem_rd_data.key;
      res.bouncing         = bounce;
      state_next           = ST_IDLE;
    end else if (accept) begin
      res_push = 1'b1;
      case (req.req_type)
        drpi_pkg::REQ_DUMP: begin
          if (req.header[drpi_pkg::TYPE_LSB +: 2] == drpi_pkg::TYPE_MCAST) begin
            if (tail_inc != head) begin
              mem_wr_en = 1'b1;
              tail_next = tail_inc;
            end else begin
              res.dropped = 1'b1;
            end
          end
        end
        drpi_pkg::REQ_TICK: begin
          if (!req.router_blocked && !empty) begin
            bounce_next = 1'b1;
          end
        end
        drpi_pkg::REQ_TXRDY: begin
          if (bounce) begin
            if (!req.router_blocked && !empty) begin
              // result goes out once the store read returns
              res_push   = 1'b0;
              mem_rd_en  = 1'b1;
              head_next  = head_inc;
              state_next = ST_READ;
            end else begin
              bounce_next = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
      res.bouncing = bounce_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      tail      <= '0;
      bounce    <= 1'b0;
      source_id <= '0;
    end else begin
      state  <= state_next;
      head   <= head_next;
      tail   <= tail_next;
      bounce <= bounce_next;
      if (cfg_wr_en) begin
        source_id <= cfg_wr_data;
      end
    end
  end

endmodule

@@ rtl/dumped_packet_reinjector.sv @@
// Top level of the dumped packet reinjector.
// Depends on drpi_pkg, drpi_ram, drpi_outq and drpi_ctrl.

// Holds multicast packets dumped by the router and sends them back in.
// Each request carries a type: dump (header, key, payload), timer tick, or
// transmitter ready. Multicast dumps (header bits 23:22 == 0) are written
// into a circular queue in a synchronous RAM that always keeps one slot
// free, so it holds up to QUEUE_DEPTH-1 packets; a multicast dump that
// meets a full queue comes back with dropped set. A tick turns bouncing on
// when the router is not blocked and the queue holds packets. A transmitter
// ready request is only acted on while bouncing is on: it either pops the
// head packet (send set, control byte, route bits, source id, key and the
// payload when header bit 17 is set) or turns bouncing off. Every request
// gives exactly one response; bouncing in it is the flag after the request.
// A pop waits for the registered read of the queue RAM, and no new request
// is taken during the read cycle. A two-entry response queue lets requests
// keep flowing while a response waits on rsp_stall. The RAM needs no clearing
// after reset; the pointers alone mark what it holds. source_id must only be
// written while no request is in flight.
module dumped_packet_reinjector #(
  parameter int QUEUE_DEPTH = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic [7:0]      cfg_wr_data,
  input  logic            req_valid,
  output logic            req_stall,
  input  drpi_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output drpi_pkg::rsp_t  rsp
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int EntryW = $bits(drpi_pkg::entry_t);

  logic             q_full;
  logic             res_push;
  drpi_pkg::rsp_t   res;
  logic             busy;
  logic             mem_wr_en;
  logic [PtrW-1:0]  mem_wr_addr;
  drpi_pkg::entry_t mem_wr_data;
  logic             mem_rd_en;
  logic [PtrW-1:0]  mem_rd_addr;
  drpi_pkg::entry_t mem_rd_data;
  logic [EntryW-1:0] mem_rd_raw;

  // request sequencer and queue pointers
  drpi_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .q_full     (q_full),
    .res_push   (res_push),
    .res        (res),
    .busy       (busy),
    .mem_wr_en  (mem_wr_en),
    .mem_wr_addr(mem_wr_addr),
    .mem_wr_data(mem_wr_data),
    .mem_rd_en  (mem_rd_en),
    .mem_rd_addr(mem_rd_addr),
    .mem_rd_data(mem_rd_data)
  );

  // packet store
  drpi_ram #(
    .WIDTH(EntryW),
    .DEPTH(QUEUE_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_raw)
  );

  assign mem_rd_data = drpi_pkg::entry_t'(mem_rd_raw);

  // response buffering
  drpi_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (res_push),
    .push_data(res),
    .full     (q_full),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  // a response is never pushed into a full buffer unless one leaves
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (!q_full || (rsp_valid && !rsp_stall)))
    else $error("response pushed into full buffer");

  // the read cycle always follows an accepted pop request
  a_read_after_pop: assert property (@(posedge clk) disable iff (rst)
    busy |-> ($past(req_valid) && !$past(req_stall)
              && $past(req.req_type) == drpi_pkg::REQ_TXRDY))
    else $error("read cycle without pop request");

  // a re-injected packet implies bouncing stays on
  a_send_bouncing: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.send) |-> (rsp.bouncing && !rsp.dropped))
    else $error("send without bouncing");

endmodule
